// ----- design/cup_weight_event_detector_core_assert.svh -----
// assertion macros for the cup weight event detector
// no dependencies; taken in by the top level only
`ifndef CUP_WEIGHT_EVENT_DETECTOR_CORE_ASSERT_SVH
`define CUP_WEIGHT_EVENT_DETECTOR_CORE_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define CWED_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: property violated");
// next-cycle implication
`define CWED_ASSERT_NXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: property violated");
`else
`define CWED_ASSERT_IMP(name, clk, rst, ante, cons)
`define CWED_ASSERT_NXT(name, clk, rst, ante, cons)
`endif

`endif

// ----- design/cwed_pkg.sv -----
// shared constants and types for the cup weight event detector
// no dependencies; used by the interfaces and the top level
package cwed_pkg;

  localparam int WEIGHT_W    = 17;
  localparam int RAW_W       = 18;
  localparam int TOTAL_W     = 22;
  localparam int EVENT_W     = 3;
  localparam int MODE_W      = 2;
  localparam int CFG_INDEX_W = 2;

  localparam int WINDOW_LEN_DEF = 5;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = 22'h3FFFFF;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_PRESENCE_THRESHOLD = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_STABILITY_BAND     = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_CHANGE_MARGIN      = 2'd2;

  localparam logic [WEIGHT_W-1:0] PRESENCE_THRESHOLD_RST = 17'd150;
  localparam logic [WEIGHT_W-1:0] STABILITY_BAND_RST     = 17'd25;
  localparam logic [WEIGHT_W-1:0] CHANGE_MARGIN_RST      = 17'd50;

  // event codes
  localparam logic [EVENT_W-1:0] EV_NONE     = 3'd0;
  localparam logic [EVENT_W-1:0] EV_PLACED   = 3'd1;
  localparam logic [EVENT_W-1:0] EV_LIFTED   = 3'd2;
  localparam logic [EVENT_W-1:0] EV_DRANK    = 3'd3;
  localparam logic [EVENT_W-1:0] EV_REFILLED = 3'd4;
  localparam logic [EVENT_W-1:0] EV_SAME     = 3'd5;
  localparam logic [EVENT_W-1:0] EV_EMPTIED  = 3'd6;
  localparam logic [EVENT_W-1:0] EV_RESET    = 3'd7;

  // mode codes as reported on the result channel
  localparam logic [MODE_W-1:0] MODE_CODE_EMPTY  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CODE_PLACED = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CODE_LIFTED = 2'd2;

  typedef enum logic [2:0] {
    MODE_EMPTY  = 3'b001,
    MODE_PLACED = 3'b010,
    MODE_LIFTED = 3'b100
  } mode_t;

  typedef struct packed {
    logic [EVENT_W-1:0]  event_code;
    logic [MODE_W-1:0]   mode_now;
    logic                window_stable;
    logic [WEIGHT_W-1:0] drink_amount;
    logic [TOTAL_W-1:0]  total_consumed;
    logic                report_now;
  } result_t;

endpackage

// ----- design/cwed_if.sv -----
// channel interfaces: sample input, result output, register writes
// depends on cwed_pkg
interface cwed_sample_if;
  logic                              valid;
  logic                              ready;
  logic                              action;
  logic signed [cwed_pkg::RAW_W-1:0] sample_weight;

  modport source (output valid, output action, output sample_weight, input ready);
  modport sink   (input valid, input action, input sample_weight, output ready);
endinterface

interface cwed_result_if;
  logic                             valid;
  logic                             ready;
  logic [cwed_pkg::EVENT_W-1:0]     event_code;
  logic [cwed_pkg::MODE_W-1:0]      mode_now;
  logic                             window_stable;
  logic [cwed_pkg::WEIGHT_W-1:0]    drink_amount;
  logic [cwed_pkg::TOTAL_W-1:0]     total_consumed;
  logic                             report_now;

  modport source (output valid, output event_code, output mode_now, output window_stable,
                  output drink_amount, output total_consumed, output report_now,
                  input ready);
  modport sink   (input valid, input event_code, input mode_now, input window_stable,
                  input drink_amount, input total_consumed, input report_now,
                  output ready);
endinterface

interface cwed_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [cwed_pkg::CFG_INDEX_W-1:0] index;
  logic [cwed_pkg::WEIGHT_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- design/cup_weight_event_detector_core.sv -----
// Cup weight event detector core.
// Channels: sample (action + signed weight in 0.1 g), result (one beat per
// sample beat), cfg (register writes: 0 presence threshold, 1 stability band,
// 2 change margin; always ready). The user must write cfg only while the
// block is idle; the block itself does not enforce this. Each sample beat
// gives exactly one result beat, in order. A reset beat (action = 1) clears
// the total, window and mode and answers with event 7. A sample beat enters
// the input register, then the window/state update is written into the
// result register. Throughput: one beat per cycle while the receiver does
// not stall; the window max/min and the mode update are a single
// combinational pass between the two registers.
// When the receiver stalls, the result register holds its beat and the input
// register keeps taking one more beat; sample.ready falls only when both are
// full and result.ready is low.
// Reset (rst, synchronous): both stages empty, config registers to defaults,
// window empty, mode empty, total zero. No events are reported until the
// window has filled with WINDOW_LEN samples.
// depends on cwed_pkg, cwed_if.sv and cup_weight_event_detector_core_assert.svh
`include "cup_weight_event_detector_core_assert.svh"

module cup_weight_event_detector_core #(
  parameter int WINDOW_LEN = cwed_pkg::WINDOW_LEN_DEF
) (
  input  logic           clk,
  input  logic           rst,
  cwed_sample_if.sink    sample,
  cwed_result_if.source  result,
  cwed_cfg_if.sink       cfg
);

  localparam int W   = cwed_pkg::WEIGHT_W;
  localparam int TW  = cwed_pkg::TOTAL_W;
  localparam int CNT_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;

  // configuration
  logic [W-1:0] presence_threshold;
  logic [W-1:0] stability_band;
  logic [W-1:0] change_margin;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      presence_threshold <= cwed_pkg::PRESENCE_THRESHOLD_RST;
      stability_band     <= cwed_pkg::STABILITY_BAND_RST;
      change_margin      <= cwed_pkg::CHANGE_MARGIN_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        cwed_pkg::REG_PRESENCE_THRESHOLD: presence_threshold <= cfg.data;
        cwed_pkg::REG_STABILITY_BAND:     stability_band     <= cfg.data;
        cwed_pkg::REG_CHANGE_MARGIN:      change_margin      <= cfg.data;
        default: ;
      endcase
    end
  end

  // input register and result register handshake
  logic                              in_valid;
  logic                              in_action;
  logic signed [cwed_pkg::RAW_W-1:0] in_weight;
  logic                              res_valid;
  cwed_pkg::result_t                 res;
  logic                              res_free;
  logic                              advance;

  assign res_free     = !res_valid || result.ready;
  assign advance      = in_valid && res_free;
  assign sample.ready = !in_valid || res_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (sample.ready) begin
      in_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      in_action <= sample.action;
      in_weight <= sample.sample_weight;
    end
  end

  // detector state
  logic [W-1:0]     taps [WINDOW_LEN];
  logic [CNT_W-1:0] fill_cnt;
  logic             win_full;
  cwed_pkg::mode_t  mode;
  logic [W-1:0]     settled;
  logic [W-1:0]     lift_weight;
  logic [TW-1:0]    total;

  // window after this sample goes in
  logic [W-1:0] w;
  logic [W-1:0] new_taps [WINDOW_LEN];
  logic [W-1:0] win_max;
  logic [W-1:0] win_min;
  logic         full_now;

  assign w        = in_weight[cwed_pkg::RAW_W-1] ? '0 : in_weight[W-1:0];
  assign full_now = win_full || (fill_cnt == CNT_W'(WINDOW_LEN - 1));

  always_comb begin
    new_taps[0] = w;
    for (int i = 1; i < WINDOW_LEN; i++) begin
      new_taps[i] = taps[i-1];
    end
  end

  always_comb begin
    win_max = new_taps[0];
    win_min = new_taps[0];
    for (int i = 1; i < WINDOW_LEN; i++) begin
      if (new_taps[i] > win_max) win_max = new_taps[i];
      if (new_taps[i] < win_min) win_min = new_taps[i];
    end
  end

  logic            stable;
  logic            present;
  logic [W:0]      w_plus_margin;
  logic [W:0]      settled_plus_margin;
  logic [W:0]      lift_plus_margin;
  logic            lift_valid;
  cwed_pkg::mode_t mode_next;
  logic [W-1:0]    settled_next;
  logic [W-1:0]    lift_weight_next;
  logic [TW-1:0]   total_next;
  logic [2:0]      ev;
  logic [W-1:0]    drop;
  logic [TW:0]     total_sum;
  logic            do_return;

  assign stable              = full_now && ((win_max - win_min) <= stability_band);
  assign present             = w > presence_threshold;
  assign w_plus_margin       = {1'b0, w} + {1'b0, change_margin};
  assign settled_plus_margin = {1'b0, settled} + {1'b0, change_margin};
  assign lift_plus_margin    = {1'b0, lift_weight} + {1'b0, change_margin};
  assign lift_valid          = lift_weight > presence_threshold;

  always_comb begin
    mode_next        = mode;
    settled_next     = settled;
    lift_weight_next = lift_weight;
    ev               = cwed_pkg::EV_NONE;
    drop             = '0;
    do_return        = 1'b0;
    if (full_now) begin
      unique case (mode)
        cwed_pkg::MODE_PLACED: begin
          if (!present) begin
            mode_next        = cwed_pkg::MODE_LIFTED;
            lift_weight_next = settled;
            ev               = cwed_pkg::EV_LIFTED;
          end else if (stable) begin
            if (w_plus_margin < {1'b0, settled}) begin
              drop         = settled - w;
              settled_next = w;
              ev           = cwed_pkg::EV_DRANK;
            end else if ({1'b0, w} > settled_plus_margin) begin
              settled_next = w;
              ev           = cwed_pkg::EV_REFILLED;
            end
          end
        end
        cwed_pkg::MODE_LIFTED: begin
          if (present && stable) begin
            do_return = 1'b1;
          end else if (!present && stable) begin
            mode_next    = cwed_pkg::MODE_EMPTY;
            settled_next = '0;
            ev           = cwed_pkg::EV_EMPTIED;
          end
        end
        default: begin
          mode_next = cwed_pkg::MODE_EMPTY;
          do_return = present && stable;
        end
      endcase
    end
    // cup settles back on the scale
    if (do_return) begin
      mode_next    = cwed_pkg::MODE_PLACED;
      settled_next = w;
      ev           = cwed_pkg::EV_PLACED;
      if (lift_valid) begin
        if (w_plus_margin < {1'b0, lift_weight}) begin
          drop = lift_weight - w;
          ev   = cwed_pkg::EV_DRANK;
        end else if ({1'b0, w} > lift_plus_margin) begin
          ev = cwed_pkg::EV_REFILLED;
        end else begin
          ev = cwed_pkg::EV_SAME;
        end
        lift_weight_next = '0;
      end
    end
  end

  assign total_sum  = {1'b0, total} + (TW+1)'(drop);
  assign total_next = (ev != cwed_pkg::EV_DRANK) ? total :
                      (total_sum > {1'b0, cwed_pkg::TOTAL_MAX}) ? cwed_pkg::TOTAL_MAX :
                      total_sum[TW-1:0];

  // window taps are fully overwritten before the window counts as full again
  always_ff @(posedge clk) begin
    if (advance && !in_action) begin
      for (int i = 0; i < WINDOW_LEN; i++) begin
        taps[i] <= new_taps[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_cnt    <= '0;
      win_full    <= 1'b0;
      mode        <= cwed_pkg::MODE_EMPTY;
      settled     <= '0;
      lift_weight <= '0;
      total       <= '0;
    end else if (advance) begin
      if (in_action) begin
        fill_cnt <= '0;
        win_full <= 1'b0;
        mode     <= cwed_pkg::MODE_EMPTY;
        total    <= '0;
      end else begin
        if (!full_now) fill_cnt <= fill_cnt + 1'b1;
        win_full    <= full_now;
        mode        <= mode_next;
        settled     <= settled_next;
        lift_weight <= lift_weight_next;
        total       <= total_next;
      end
    end
  end

  function automatic logic [cwed_pkg::MODE_W-1:0] mode_code(cwed_pkg::mode_t m);
    unique case (m)
      cwed_pkg::MODE_PLACED: mode_code = cwed_pkg::MODE_CODE_PLACED;
      cwed_pkg::MODE_LIFTED: mode_code = cwed_pkg::MODE_CODE_LIFTED;
      default:               mode_code = cwed_pkg::MODE_CODE_EMPTY;
    endcase
  endfunction

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_free) begin
      res_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (in_action) begin
        res.event_code     <= cwed_pkg::EV_RESET;
        res.mode_now       <= cwed_pkg::MODE_CODE_EMPTY;
        res.window_stable  <= 1'b0;
        res.drink_amount   <= '0;
        res.total_consumed <= '0;
        res.report_now     <= 1'b0;
      end else begin
        res.event_code     <= ev;
        res.mode_now       <= mode_code(mode_next);
        res.window_stable  <= stable;
        res.drink_amount   <= drop;
        res.total_consumed <= total_next;
        res.report_now     <= (ev == cwed_pkg::EV_DRANK);
      end
    end
  end

  assign result.valid          = res_valid;
  assign result.event_code     = res.event_code;
  assign result.mode_now       = res.mode_now;
  assign result.window_stable  = res.window_stable;
  assign result.drink_amount   = res.drink_amount;
  assign result.total_consumed = res.total_consumed;
  assign result.report_now     = res.report_now;

  // checks
  `CWED_ASSERT_IMP(a_mode_onehot, clk, rst, 1'b1, $onehot(mode))
  `CWED_ASSERT_NXT(a_reset_clears_window, clk, rst, advance && in_action,
                   !win_full && (total == '0) && (mode == cwed_pkg::MODE_EMPTY))
  `CWED_ASSERT_NXT(a_total_monotonic, clk, rst, advance && !in_action,
                   total >= $past(total))
  `CWED_ASSERT_IMP(a_report_on_drink, clk, rst, res_valid,
                   res.report_now == (res.event_code == cwed_pkg::EV_DRANK))

endmodule
